// ===== design/hiwa_pkg.sv =====
// Package for the homography inverse-warp address generator.
// Holds shared widths, payload structs and register index codes; no dependencies.
package hiwa_pkg;

    // Field and coefficient widths
    localparam int COORD_W = 10;
    localparam int COEF_W  = 48;
    localparam int FRAC_W  = 32;

    // Arithmetic widths: 48s x 11s products, three-term sums, magnitudes
    localparam int PROD_W = COEF_W + COORD_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int MAG_W  = SUM_W;
    localparam int NUM_W  = MAG_W + 2;
    localparam int DEN_W  = MAG_W + 1;

    // Configuration port
    localparam int CFG_IDX_W = 4;

    // Default frame size
    localparam int FRAME_WIDTH_DEF  = 1024;
    localparam int FRAME_HEIGHT_DEF = 1024;

    // Register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_M00 = 4'd0,
        REG_M01 = 4'd1,
        REG_M02 = 4'd2,
        REG_M10 = 4'd3,
        REG_M11 = 4'd4,
        REG_M12 = 4'd5,
        REG_M20 = 4'd6,
        REG_M21 = 4'd7
    } t_reg_idx;

    // Reset values: identity mapping
    localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << FRAC_W;
    localparam logic [COEF_W-1:0] COEF_ZERO = '0;

    // Input item
    typedef struct packed {
        logic [COORD_W-1:0] dst_x;
        logic [COORD_W-1:0] dst_y;
    } t_in;

    // Result item
    typedef struct packed {
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic               in_range;
    } t_out;

    // Side information that travels alongside the dividers
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero;
    } t_side;

    // Full coefficient set
    typedef struct packed {
        logic signed [COEF_W-1:0] m00;
        logic signed [COEF_W-1:0] m01;
        logic signed [COEF_W-1:0] m02;
        logic signed [COEF_W-1:0] m10;
        logic signed [COEF_W-1:0] m11;
        logic signed [COEF_W-1:0] m12;
        logic signed [COEF_W-1:0] m20;
        logic signed [COEF_W-1:0] m21;
    } t_coef;

endpackage

// ===== design/hiwa_proj.sv =====
// Projection front end: products, sums, signs and rounding operands (4 stages).
// Depends on hiwa_pkg.
module hiwa_proj (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  hiwa_pkg::t_in            i_in,
    input  hiwa_pkg::t_coef          i_coef,
    output logic                     o_valid,
    output logic [hiwa_pkg::NUM_W-1:0] o_num_x,
    output logic [hiwa_pkg::NUM_W-1:0] o_num_y,
    output logic [hiwa_pkg::DEN_W-1:0] o_den,
    output hiwa_pkg::t_side          o_side
);
    import hiwa_pkg::*;

    localparam logic signed [SUM_W-1:0] Z_ONE = SUM_W'(1) << FRAC_W;

    logic [3:0] r_valid;

    logic signed [COORD_W:0]  w_x;
    logic signed [COORD_W:0]  w_y;
    logic signed [PROD_W-1:0] n_p [6];
    logic signed [PROD_W-1:0] r_p [6];

    logic signed [SUM_W-1:0] r_nx, r_ny, r_z;

    logic [MAG_W-1:0] r_ax, r_ay, r_az;
    t_side            r_side3;

    // Valid bits move with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    // Stage 1: six coefficient products
    assign w_x = $signed({1'b0, i_in.dst_x});
    assign w_y = $signed({1'b0, i_in.dst_y});

    always_comb begin
        n_p[0] = i_coef.m00 * w_x;
        n_p[1] = i_coef.m01 * w_y;
        n_p[2] = i_coef.m10 * w_x;
        n_p[3] = i_coef.m11 * w_y;
        n_p[4] = i_coef.m20 * w_x;
        n_p[5] = i_coef.m21 * w_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) begin
                r_p[k] <= n_p[k];
            end
        end
    end

    // Stage 2: numerators and denominator
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx <= SUM_W'(r_p[0]) + SUM_W'(r_p[1]) + SUM_W'(i_coef.m02);
            r_ny <= SUM_W'(r_p[2]) + SUM_W'(r_p[3]) + SUM_W'(i_coef.m12);
            r_z  <= SUM_W'(r_p[4]) + SUM_W'(r_p[5]) + Z_ONE;
        end
    end

    // Stage 3: magnitudes and quotient signs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax          <= r_nx[SUM_W-1] ? MAG_W'(-r_nx) : MAG_W'(r_nx);
            r_ay          <= r_ny[SUM_W-1] ? MAG_W'(-r_ny) : MAG_W'(r_ny);
            r_az          <= r_z[SUM_W-1]  ? MAG_W'(-r_z)  : MAG_W'(r_z);
            r_side3.neg_x <= r_nx[SUM_W-1] ^ r_z[SUM_W-1];
            r_side3.neg_y <= r_ny[SUM_W-1] ^ r_z[SUM_W-1];
            r_side3.zero  <= (r_z == '0);
        end
    end

    // Stage 4: rounding operands, 2|n| + |z| over 2|z|
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num_x <= (NUM_W'(r_ax) << 1) + NUM_W'(r_az);
            o_num_y <= (NUM_W'(r_ay) << 1) + NUM_W'(r_az);
            o_den   <= DEN_W'(r_az) << 1;
            o_side  <= r_side3;
        end
    end

    assign o_valid = r_valid[3];

endmodule

// ===== design/hiwa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, top bit flags overflow.
// Depends on hiwa_pkg.
module hiwa_div #(
    parameter int QB = 11
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [hiwa_pkg::NUM_W-1:0] i_num,
    input  logic [hiwa_pkg::DEN_W-1:0] i_den,
    output logic [QB:0]                o_quo
);
    import hiwa_pkg::*;

    localparam int NS = QB + 1;
    localparam int RW = DEN_W + QB + 1;

    logic [RW-1:0]    r_rem [NS];
    logic [DEN_W-1:0] r_den [NS];
    logic [QB:0]      r_quo [NS];

    // Each stage tests one shifted divisor, most significant bit first
    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int SH = QB - s;
        logic [RW-1:0]    w_rem;
        logic [DEN_W-1:0] w_den;
        logic [QB:0]      w_quo;
        logic [RW-1:0]    w_dsh;
        logic             w_ge;

        if (s == 0) begin : g_first
            assign w_rem = RW'(i_num);
            assign w_den = i_den;
            assign w_quo = '0;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_den = r_den[s-1];
            assign w_quo = r_quo[s-1];
        end

        assign w_dsh = RW'(w_den) << SH;
        assign w_ge  = (w_rem >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? (w_rem - w_dsh) : w_rem;
                r_den[s] <= w_den;
                r_quo[s] <= w_quo | ((QB+1)'(w_ge) << SH);
            end
        end
    end

    assign o_quo = r_quo[NS-1];

endmodule

// ===== design/homography_inverse_warp_address.sv =====
// Homography inverse-warp address generator, nearest neighbor.
// Depends on hiwa_pkg, hiwa_proj and hiwa_div.
//
// Usage:
//   Input channel i_in_valid / o_in_stall carries one output pixel coordinate
//   (dst_x, dst_y) per item. Output channel o_out_valid / i_out_stall returns
//   the rounded source coordinate and an in-range flag for every item, in order.
//   The configuration port writes one of the eight Q15.32 coefficients at each
//   clock with i_cfg_we high; indexes of 8 or more are ignored. Write only while
//   no items are in flight.
//   Items pass through four projection stages, one divider stage per quotient
//   bit and one output register. Throughput is one item per cycle unless the
//   pipeline is held by a receiver stall.
//   Reset loads the identity matrix and empties the pipeline.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and o_in_stall rises in the same cycle; nothing is lost or repeated.
//   An item out of the frame or with zero denominator gives in_range 0 and
//   coordinates 0, which downstream fills with white.
module homography_inverse_warp_address #(
    parameter int FRAME_WIDTH  = hiwa_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = hiwa_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  hiwa_pkg::t_in                  i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output hiwa_pkg::t_out                 o_out,
    input  logic                           i_cfg_we,
    input  logic [hiwa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hiwa_pkg::COEF_W-1:0]    i_cfg_data
);
    import hiwa_pkg::*;

    localparam int MAX_DIM = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
    localparam int QB      = $clog2(MAX_DIM + 1);
    localparam int NS      = QB + 1;
    localparam logic [QB:0] LIM_X = (QB+1)'(FRAME_WIDTH);
    localparam logic [QB:0] LIM_Y = (QB+1)'(FRAME_HEIGHT);

    t_coef r_coef;
    logic  w_en;

    logic             w_pv;
    logic [NUM_W-1:0] w_num_x, w_num_y;
    logic [DEN_W-1:0] w_den;
    t_side            w_side;

    logic [QB:0] w_qx, w_qy;
    logic [NS-1:0] r_dv;
    t_side         r_dside [NS];

    logic              w_bad_x, w_bad_y, w_ok;
    logic [QB+COORD_W:0] w_ex, w_ey;
    logic              r_out_valid;
    t_out              r_out;

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= {COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO,
                       COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_M00: r_coef.m00 <= i_cfg_data;
                REG_M01: r_coef.m01 <= i_cfg_data;
                REG_M02: r_coef.m02 <= i_cfg_data;
                REG_M10: r_coef.m10 <= i_cfg_data;
                REG_M11: r_coef.m11 <= i_cfg_data;
                REG_M12: r_coef.m12 <= i_cfg_data;
                REG_M20: r_coef.m20 <= i_cfg_data;
                REG_M21: r_coef.m21 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline advances unless a finished result is held by the receiver
    assign w_en       = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    // Projection front end
    hiwa_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_in    (i_in),
        .i_coef  (r_coef),
        .o_valid (w_pv),
        .o_num_x (w_num_x),
        .o_num_y (w_num_y),
        .o_den   (w_den),
        .o_side  (w_side)
    );

    // One divider lane per coordinate
    hiwa_div #(.QB(QB)) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_num_x),
        .i_den (w_den),
        .o_quo (w_qx)
    );

    hiwa_div #(.QB(QB)) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_num_y),
        .i_den (w_den),
        .o_quo (w_qy)
    );

    // Valid bits and side information follow the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (w_en) begin
            r_dv <= {r_dv[NS-2:0], w_pv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dside[0] <= w_side;
            for (int s = 1; s < NS; s++) begin
                r_dside[s] <= r_dside[s-1];
            end
        end
    end

    // Range test: a zero denominator, a negative nonzero quotient, overflow or limit rejects the point
    assign w_bad_x = (r_dside[NS-1].neg_x && (w_qx != '0)) || (w_qx >= LIM_X);
    assign w_bad_y = (r_dside[NS-1].neg_y && (w_qy != '0)) || (w_qy >= LIM_Y);
    assign w_ok    = !r_dside[NS-1].zero && !w_bad_x && !w_bad_y;
    assign w_ex    = {{COORD_W{1'b0}}, w_qx};
    assign w_ey    = {{COORD_W{1'b0}}, w_qy};

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_dv[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.src_x    <= w_ok ? w_ex[COORD_W-1:0] : '0;
            r_out.src_y    <= w_ok ? w_ey[COORD_W-1:0] : '0;
            r_out.in_range <= w_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== design/hiwa_checker.sv =====
// Port-level checker for the inverse-warp address generator, with its bind.
// Depends on hiwa_pkg.
module hiwa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input hiwa_pkg::t_out                 o_out
);
    import hiwa_pkg::*;

    // The input side stalls exactly when a result is held
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall does not follow held result");

    // A rejected point reports zero coordinates
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.in_range) |-> (o_out.src_x == '0 && o_out.src_y == '0))
        else $error("out-of-range result has nonzero coordinates");

    // A held result stays valid
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // A held result does not change
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out))
        else $error("result changed while stalled");

endmodule

bind homography_inverse_warp_address hiwa_checker u_hiwa_checker (.*);
